// ----- rtl/pfte_pkg.sv -----
// Shared types and constants for the page framebuffer text engine.
// No dependencies; imported by page_framebuffer_text_engine.
package pfte_pkg;

    localparam int SCREEN_WIDTH_DEF  = 128;
    localparam int SCREEN_HEIGHT_DEF = 64;

    localparam int CMD_W   = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;
    localparam int FONT_W     = 5;

    localparam logic [FONT_W-1:0] FONT_WIDTH_RST  = 5'd7;
    localparam logic [FONT_W-1:0] FONT_HEIGHT_RST = 5'd10;

    localparam logic [15:0] PIXEL_BIT  = 16'h8000;
    localparam logic [7:0]  BYTE_WHITE = 8'hFF;
    localparam logic [7:0]  BYTE_BLACK = 8'h00;

    localparam logic [CFG_IDX_W-1:0] CFG_FONT_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FONT_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT      = 2'd2;

    typedef enum logic [CMD_W-1:0] {
        CMD_PIXEL  = 3'd0,
        CMD_FILL   = 3'd1,
        CMD_CURSOR = 3'd2,
        CMD_GLYPH  = 3'd3,
        CMD_READ   = 3'd4
    } t_cmd;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RMW,
        S_READ,
        S_RDOUT
    } t_state;

endpackage

// ----- rtl/page_framebuffer_text_engine.sv -----
// Page framebuffer text engine: one sequencer around a byte memory with a read-modify-write lane.
// Depends on pfte_pkg. Set cursor, rejected, unknown and off-screen glyph rows answer from idle;
//   read byte passes S_READ and S_RDOUT; pixel and glyph row use S_RMW; fill writes W*H/8 bytes,
//   one byte per cycle through the memory port pair (one read, one write per cycle).
// Throughput: next word taken in the cycle the result strobe is shown.
// Reset: synchronous active low; a clearing pass writes white to all W*H/8 bytes.
module page_framebuffer_text_engine #(
    parameter int SCREEN_WIDTH  = pfte_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = pfte_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    output logic                            o_busy,
    input  logic [pfte_pkg::CMD_W-1:0]      i_cmd,
    input  logic [7:0]                      i_pos_x,
    input  logic [7:0]                      i_pos_y,
    input  logic                            i_color,
    input  logic [15:0]                     i_row_bits,
    input  logic [3:0]                      i_row_index,
    input  logic                            i_last_row,
    input  logic [2:0]                      i_page,
    input  logic [6:0]                      i_column,
    output logic                            o_strobe,
    output logic                            o_status,
    output logic [7:0]                      o_read_data,
    output logic [7:0]                      o_cursor_col,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [pfte_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pfte_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import pfte_pkg::*;

    localparam int DEPTH = SCREEN_WIDTH * (SCREEN_HEIGHT / 8);
    localparam int AW    = $clog2(DEPTH);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    logic [7:0] mem [DEPTH];

    t_state r_state, n_state;

    logic [AW-1:0]     r_addr, n_addr;
    logic [FONT_W-1:0] r_left, n_left;
    logic              r_wr_pend, n_wr_pend;
    logic [AW-1:0]     r_wr_addr, n_wr_addr;
    logic              r_wr_white, n_wr_white;
    logic [15:0]       r_shift, n_shift;
    logic              r_color, n_color;
    logic [7:0]        r_mask, n_mask;
    logic [7:0]        r_fill_byte, n_fill_byte;
    logic              r_fill_resp, n_fill_resp;
    logic [7:0]        r_cursor_x, n_cursor_x;
    logic [7:0]        r_cursor_y, n_cursor_y;
    logic              r_strobe, n_strobe;
    logic              r_status, n_status;
    logic [7:0]        r_read_data, n_read_data;
    logic [7:0]        r_out_col, n_out_col;
    logic [7:0]        r_rdata;

    logic [FONT_W-1:0] r_font_width;
    logic [FONT_W-1:0] r_font_height;
    logic              r_invert;

    logic          w_accept;
    t_cmd          w_cmd;
    logic          w_px_ok;
    logic          w_rd_ok;
    logic          w_fit;
    logic [8:0]    w_gy;
    logic          w_gy_ok;
    logic [AW-1:0] w_px_addr;
    logic [AW-1:0] w_rd_addr;
    logic [AW-1:0] w_gl_addr;
    logic [7:0]    w_adv_x;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [7:0]    w_wdata;

    assign w_accept = i_start && !o_busy;
    assign w_cmd    = t_cmd'(i_cmd);

    // Decode of the incoming word
    assign w_px_ok   = (32'(i_pos_x) < 32'(SCREEN_WIDTH)) && (32'(i_pos_y) < 32'(SCREEN_HEIGHT));
    assign w_rd_ok   = (32'(i_page) < 32'(SCREEN_HEIGHT / 8)) &&
                       (32'(i_column) < 32'(SCREEN_WIDTH));
    assign w_fit     = (9'(r_cursor_x) + 9'(r_font_width) < 9'(SCREEN_WIDTH)) &&
                       (9'(r_cursor_y) + 9'(r_font_height) < 9'(SCREEN_HEIGHT));
    assign w_gy      = 9'(r_cursor_y) + 9'(i_row_index);
    assign w_gy_ok   = w_gy < 9'(SCREEN_HEIGHT);
    assign w_px_addr = AW'(32'(i_pos_y[7:3]) * 32'(SCREEN_WIDTH) + 32'(i_pos_x));
    assign w_rd_addr = AW'(32'(i_page) * 32'(SCREEN_WIDTH) + 32'(i_column));
    assign w_gl_addr = AW'(32'(w_gy[8:3]) * 32'(SCREEN_WIDTH) + 32'(r_cursor_x));
    assign w_adv_x   = 8'(9'(r_cursor_x) + 9'(r_font_width));

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_addr == LAST_ADDR) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (w_accept) begin
                    case (w_cmd)
                        CMD_FILL:  n_state = S_CLEAR;
                        CMD_PIXEL: if (w_px_ok) n_state = S_RMW;
                        CMD_GLYPH: if (w_fit && w_gy_ok) n_state = S_RMW;
                        CMD_READ:  if (w_rd_ok) n_state = S_READ;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_RMW: begin
                if (r_left == '0 && !r_wr_pend) n_state = S_IDLE;
            end
            S_READ:  n_state = S_RDOUT;
            S_RDOUT: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Memory write port and handshake outputs
    always_comb begin
        o_busy  = (r_state != S_IDLE);
        w_we    = 1'b0;
        w_waddr = r_addr;
        w_wdata = r_fill_byte;
        case (r_state)
            S_CLEAR: w_we = 1'b1;
            S_RMW: begin
                w_we    = r_wr_pend;
                w_waddr = r_wr_addr;
                w_wdata = r_wr_white ? (r_rdata | r_mask) : (r_rdata & ~r_mask);
            end
            default: w_we = 1'b0;
        endcase
    end

    // Datapath next values
    always_comb begin
        n_addr      = r_addr;
        n_left      = r_left;
        n_wr_pend   = r_wr_pend;
        n_wr_addr   = r_wr_addr;
        n_wr_white  = r_wr_white;
        n_shift     = r_shift;
        n_color     = r_color;
        n_mask      = r_mask;
        n_fill_byte = r_fill_byte;
        n_fill_resp = r_fill_resp;
        n_cursor_x  = r_cursor_x;
        n_cursor_y  = r_cursor_y;
        n_strobe    = 1'b0;
        n_status    = r_status;
        n_read_data = r_read_data;
        n_out_col   = r_out_col;
        case (r_state)
            S_CLEAR: begin
                n_addr = r_addr + 1'b1;
                if (r_addr == LAST_ADDR) begin
                    n_strobe    = r_fill_resp;
                    n_fill_resp = 1'b0;
                    n_status    = 1'b0;
                    n_read_data = BYTE_BLACK;
                    n_out_col   = r_cursor_x;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_wr_pend   = 1'b0;
                    n_read_data = BYTE_BLACK;
                    n_out_col   = r_cursor_x;
                    n_status    = 1'b0;
                    case (w_cmd)
                        CMD_PIXEL: begin
                            n_addr  = w_px_addr;
                            n_left  = FONT_W'(1);
                            n_shift = PIXEL_BIT;
                            n_color = i_color;
                            n_mask  = 8'(1) << i_pos_y[2:0];
                            if (!w_px_ok) begin
                                n_strobe = 1'b1;
                                n_status = 1'b1;
                            end
                        end
                        CMD_FILL: begin
                            n_addr      = '0;
                            n_fill_byte = i_color ? BYTE_WHITE : BYTE_BLACK;
                            n_fill_resp = 1'b1;
                        end
                        CMD_CURSOR: begin
                            n_cursor_x = i_pos_x;
                            n_cursor_y = i_pos_y;
                            n_out_col  = i_pos_x;
                            n_strobe   = 1'b1;
                        end
                        CMD_GLYPH: begin
                            n_addr  = w_gl_addr;
                            n_left  = r_font_width;
                            n_shift = i_row_bits;
                            n_color = i_color;
                            n_mask  = 8'(1) << w_gy[2:0];
                            if (!w_fit) begin
                                n_strobe = 1'b1;
                                n_status = 1'b1;
                            end else begin
                                if (i_last_row) begin
                                    n_cursor_x = w_adv_x;
                                    n_out_col  = w_adv_x;
                                end
                                // row entirely below the screen: nothing to paint
                                if (!w_gy_ok) n_strobe = 1'b1;
                            end
                        end
                        CMD_READ: begin
                            n_addr = w_rd_addr;
                            if (!w_rd_ok) begin
                                n_strobe = 1'b1;
                                n_status = 1'b1;
                            end
                        end
                        default: begin
                            n_strobe = 1'b1;
                            n_status = 1'b1;
                        end
                    endcase
                end
            end
            S_RMW: begin
                if (r_left != '0) begin
                    // read this column, write it back next cycle
                    n_wr_pend  = 1'b1;
                    n_wr_addr  = r_addr;
                    n_wr_white = ~(r_shift[15] ^ r_color) ^ r_invert;
                    n_addr     = r_addr + 1'b1;
                    n_left     = r_left - 1'b1;
                    n_shift    = {r_shift[14:0], 1'b0};
                end else begin
                    n_wr_pend = 1'b0;
                    if (!r_wr_pend) begin
                        n_strobe  = 1'b1;
                        n_status  = 1'b0;
                        n_out_col = r_cursor_x;
                    end
                end
            end
            S_RDOUT: begin
                n_strobe    = 1'b1;
                n_status    = 1'b0;
                n_read_data = r_rdata;
            end
            default: n_strobe = 1'b0;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_addr      <= '0;
            r_left      <= '0;
            r_wr_pend   <= 1'b0;
            r_fill_byte <= BYTE_WHITE;
            r_fill_resp <= 1'b0;
            r_cursor_x  <= '0;
            r_cursor_y  <= '0;
            r_strobe    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_left      <= n_left;
            r_wr_pend   <= n_wr_pend;
            r_fill_byte <= n_fill_byte;
            r_fill_resp <= n_fill_resp;
            r_cursor_x  <= n_cursor_x;
            r_cursor_y  <= n_cursor_y;
            r_strobe    <= n_strobe;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_wr_addr   <= n_wr_addr;
        r_wr_white  <= n_wr_white;
        r_shift     <= n_shift;
        r_color     <= n_color;
        r_mask      <= n_mask;
        r_status    <= n_status;
        r_read_data <= n_read_data;
        r_out_col   <= n_out_col;
    end

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_font_width  <= FONT_WIDTH_RST;
            r_font_height <= FONT_HEIGHT_RST;
            r_invert      <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_FONT_WIDTH:  r_font_width  <= i_cfg_data;
                CFG_FONT_HEIGHT: r_font_height <= i_cfg_data;
                CFG_INVERT:      r_invert      <= i_cfg_data[0];
                default:         r_invert      <= r_invert;
            endcase
        end
    end

    // Frame memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_we) mem[w_waddr] <= w_wdata;
        r_rdata <= mem[r_addr];
    end

    assign o_strobe     = r_strobe;
    assign o_status     = r_status;
    assign o_read_data  = r_read_data;
    assign o_cursor_col = r_out_col;

`ifndef ASSERT_OFF
    a_strobe_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ($past(w_accept) || $past(o_busy)))
        else $error("result strobe without a started or running word");

    a_wr_pend_rmw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wr_pend |-> (r_state == S_RMW))
        else $error("pending write-back outside read-modify-write");

    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_strobe)
        else $error("result strobe during memory sweep");

    a_read_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (w_cmd == CMD_READ) && w_rd_ok) |-> ##3 o_strobe)
        else $error("read byte result not on time");
`endif

endmodule
